[rtl/core/psc_pkg.sv]
// ----------------------------------------------------------------------------
// psc_pkg: shared types and constants for the pressure compensation pipeline
// Register indexes, fixed-point constants, stage counts, divider side data.
// ----------------------------------------------------------------------------
package psc_pkg;

  // configuration register indexes
  localparam logic [2:0] RegTempCoeffs  = 3'd0;
  localparam logic [2:0] RegPressCoeffA = 3'd1;
  localparam logic [2:0] RegPressCoeffB = 3'd2;
  localparam logic [2:0] RegPressCoeffL = 3'd3;

  // fine temperature offset for the pressure formula
  localparam logic signed [25:0] TfOffset = 26'sd128000;
  // 2^47 bias in the divisor term
  localparam logic [63:0] DivBias = 64'h0000_8000_0000_0000;
  // pressure numerator scale
  localparam logic [11:0] PressScale = 12'd3125;

  // pipeline depth
  localparam int DivSteps   = 64;
  localparam int PreStages  = 10;
  localparam int PostStages = 7;
  localparam int NumStages  = PreStages + DivSteps + PostStages;

  // data that rides alongside the divider
  typedef struct packed {
    logic [15:0] temp;
    logic        neg;
    logic        dvalid;
  } psc_side_t;

endpackage

[rtl/core/psc_div.sv]
// ----------------------------------------------------------------------------
// psc_div: pipelined unsigned 64/64 divider
// Restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module psc_div import psc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [63:0] den,
  input  psc_side_t   side_in,
  output logic [63:0] quo,
  output psc_side_t   side_out
);

  logic [63:0] rem_s  [1:DivSteps];
  logic [63:0] quo_s  [1:DivSteps];
  logic [63:0] den_s  [1:DivSteps];
  psc_side_t   side_s [1:DivSteps];

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic [63:0] cur_rem;
    logic [63:0] cur_quo;
    logic [63:0] cur_den;
    psc_side_t   cur_side;
    logic [64:0] trial;
    logic [64:0] diff;
    logic        fit;

    if (i == 0) begin : g_first
      assign cur_rem  = '0;
      assign cur_quo  = num;
      assign cur_den  = den;
      assign cur_side = side_in;
    end else begin : g_rest
      assign cur_rem  = rem_s[i];
      assign cur_quo  = quo_s[i];
      assign cur_den  = den_s[i];
      assign cur_side = side_s[i];
    end

    assign trial = {cur_rem, cur_quo[63]};
    assign diff  = trial - {1'b0, cur_den};
    assign fit   = (trial >= {1'b0, cur_den});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i+1]  <= fit ? diff[63:0] : trial[63:0];
        quo_s[i+1]  <= {cur_quo[62:0], fit};
        den_s[i+1]  <= cur_den;
        side_s[i+1] <= cur_side;
      end
    end
  end

  assign quo      = quo_s[DivSteps];
  assign side_out = side_s[DivSteps];

endmodule

[rtl/core/pressure_sensor_compensation_unit.sv]
// ----------------------------------------------------------------------------
// pressure_sensor_compensation_unit: fixed-point temperature/pressure compensation
// Turns raw 20-bit sensor readings into 0.01 degC and Q24.8 pascals.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one word per reading pair; m_axis returns one word per
//   input word, in order. tuser on m_axis is the pressure valid flag: it is
//   low (and pressure reads 0) when the divisor came out zero, e.g. when the
//   calibration words were never loaded.
//   Calibration is written on the cfg channel (always ready); the user must
//   write it only while the block is idle, which the block does not enforce:
//   index 0 T1..T3, 1 P1..P4, 2 P5..P8, 3 P9. Other indexes are ignored.
// Timing:
//   From accept to output valid a word passes 10 stages of multiply/add
//   front end, 64 stages of the bit-per-stage divider and 7 stages of the
//   correction back end. One word is accepted every cycle unless stalled.
// Reset (rst, synchronous) clears all calibration words and empties the
//   pipeline. When the receiver stalls, the whole pipeline holds and
//   s_axis_tready drops once the output stage is occupied; nothing is lost.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation_unit import psc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // temperature_centi[15:0], pressure_q24_8[47:16]
  output logic        m_axis_tuser,   // pressure_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // --------------------------------------------------------------------------
  // calibration registers
  // --------------------------------------------------------------------------
  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_a;
  logic [63:0] press_coeffs_b;
  logic [15:0] press_coeff_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs      <= '0;
      press_coeffs_a   <= '0;
      press_coeffs_b   <= '0;
      press_coeff_last <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegTempCoeffs:  temp_coeffs      <= cfg_data[47:0];
        RegPressCoeffA: press_coeffs_a   <= cfg_data;
        RegPressCoeffB: press_coeffs_b   <= cfg_data;
        RegPressCoeffL: press_coeff_last <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic        [15:0] t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_coeffs[15:0];
  assign t2 = temp_coeffs[31:16];
  assign t3 = temp_coeffs[47:32];
  assign p1 = press_coeffs_a[15:0];
  assign p2 = press_coeffs_a[31:16];
  assign p3 = press_coeffs_a[47:32];
  assign p4 = press_coeffs_a[63:48];
  assign p5 = press_coeffs_b[15:0];
  assign p6 = press_coeffs_b[31:16];
  assign p7 = press_coeffs_b[47:32];
  assign p8 = press_coeffs_b[63:48];
  assign p9 = press_coeff_last;

  // --------------------------------------------------------------------------
  // flow control: the whole pipe advances unless the output word is stuck
  // --------------------------------------------------------------------------
  logic                 adv;
  logic [NumStages-1:0] vld;

  assign adv           = !vld[NumStages-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[NumStages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NumStages-2:0], s_axis_tvalid};
    end
  end

  // --------------------------------------------------------------------------
  // S1: temperature differences and first products
  // --------------------------------------------------------------------------
  logic [19:0]        adc_t, adc_p;
  logic signed [17:0] dt1_w, dt2_w;

  assign adc_t = s_axis_tdata[19:0];
  assign adc_p = s_axis_tdata[39:20];
  assign dt1_w = $signed({1'b0, adc_t[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign dt2_w = $signed({2'b0, adc_t[19:4]}) - $signed({2'b0, t1});

  logic signed [33:0] r1_ta;
  logic signed [35:0] r1_sq;
  logic        [20:0] r1_pp;

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_ta <= dt1_w * t2;
      r1_sq <= dt2_w * dt2_w;
      r1_pp <= 21'h100000 - {1'b0, adc_p};
    end
  end

  // S2: v1 shift, square times T3
  logic signed [22:0] r2_v1;
  logic signed [36:0] r2_q;
  logic        [20:0] r2_pp;

  always_ff @(posedge clk) begin
    if (adv) begin
      r2_v1 <= $signed(r1_ta[33:11]);
      r2_q  <= $signed({1'b0, r1_sq[31:12]}) * t3;
      r2_pp <= r1_pp;
    end
  end

  // S3: fine temperature and its offset form
  logic signed [22:0] v2_w;
  logic signed [24:0] tf_w;
  logic signed [25:0] a_w;

  assign v2_w = $signed(r2_q[36:14]);
  assign tf_w = r2_v1 + v2_w;
  assign a_w  = tf_w - TfOffset;

  logic signed [24:0] r3_tf;
  logic signed [25:0] r3_a;
  logic        [20:0] r3_pp;

  always_ff @(posedge clk) begin
    if (adv) begin
      r3_tf <= tf_w;
      r3_a  <= a_w;
      r3_pp <= r2_pp;
    end
  end

  // S4: temperature output, a^2, a*P5, a*P2
  logic signed [27:0] t5_w;
  logic signed [19:0] tc_w;
  logic        [15:0] temp_w;

  always_comb begin
    t5_w = r3_tf * 28'sd5 + 28'sd128;
    tc_w = $signed(t5_w[27:8]);
    if (tc_w > 20'sd32767) begin
      temp_w = 16'h7FFF;
    end else if (tc_w < -20'sd32768) begin
      temp_w = 16'h8000;
    end else begin
      temp_w = tc_w[15:0];
    end
  end

  logic signed [51:0] r4_aa;
  logic signed [41:0] r4_ap5, r4_ap2;
  logic        [15:0] r4_temp;
  logic        [20:0] r4_pp;

  always_ff @(posedge clk) begin
    if (adv) begin
      r4_aa   <= r3_a * r3_a;
      r4_ap5  <= r3_a * p5;
      r4_ap2  <= r3_a * p2;
      r4_temp <= temp_w;
      r4_pp   <= r3_pp;
    end
  end

  // S5: a^2 times P6 and P3 as 32-bit limb products
  logic signed [48:0] r5_p6l, r5_p3l;
  logic signed [36:0] r5_p6h, r5_p3h;
  logic signed [41:0] r5_ap5, r5_ap2;
  logic        [15:0] r5_temp;
  logic        [20:0] r5_pp;

  always_ff @(posedge clk) begin
    if (adv) begin
      r5_p6l  <= $signed({1'b0, r4_aa[31:0]}) * p6;
      r5_p6h  <= $signed({1'b0, r4_aa[51:32]}) * p6;
      r5_p3l  <= $signed({1'b0, r4_aa[31:0]}) * p3;
      r5_p3h  <= $signed({1'b0, r4_aa[51:32]}) * p3;
      r5_ap5  <= r4_ap5;
      r5_ap2  <= r4_ap2;
      r5_temp <= r4_temp;
      r5_pp   <= r4_pp;
    end
  end

  // S6: b term and the adjusted a term, modulo 2^64
  logic signed [63:0] e_p6l, e_p6h, e_p3l, e_p3h, e_ap5, e_ap2, e_p4, m3_w;
  logic        [63:0] b_w, a2_w;

  assign e_p6l = r5_p6l;
  assign e_p6h = r5_p6h;
  assign e_p3l = r5_p3l;
  assign e_p3h = r5_p3h;
  assign e_ap5 = r5_ap5;
  assign e_ap2 = r5_ap2;
  assign e_p4  = p4;
  assign b_w   = e_p6l + (e_p6h << 32) + (e_ap5 << 17) + (e_p4 << 35);
  assign m3_w  = e_p3l + (e_p3h << 32);
  assign a2_w  = (m3_w >>> 8) + (e_ap2 << 12);

  logic [63:0] r6_b, r6_a2;
  logic [15:0] r6_temp;
  logic [20:0] r6_pp;

  always_ff @(posedge clk) begin
    if (adv) begin
      r6_b    <= b_w;
      r6_a2   <= a2_w;
      r6_temp <= r5_temp;
      r6_pp   <= r5_pp;
    end
  end

  // S7: biased divisor term and raw numerator
  logic [63:0] r7_x, r7_n;
  logic [15:0] r7_temp;

  always_ff @(posedge clk) begin
    if (adv) begin
      r7_x    <= r6_a2 + DivBias;
      r7_n    <= ({43'b0, r6_pp} << 31) - r6_b;
      r7_temp <= r6_temp;
    end
  end

  // S8: limb products for x*P1 and n*3125
  logic [47:0] r8_xl, r8_xh;
  logic [43:0] r8_nl, r8_nh;
  logic [15:0] r8_temp;

  always_ff @(posedge clk) begin
    if (adv) begin
      r8_xl   <= r7_x[31:0] * p1;
      r8_xh   <= r7_x[63:32] * p1;
      r8_nl   <= r7_n[31:0] * PressScale;
      r8_nh   <= r7_n[63:32] * PressScale;
      r8_temp <= r7_temp;
    end
  end

  // S9: divisor d and numerator
  logic [63:0] xp_w;

  assign xp_w = {16'b0, r8_xl} + {r8_xh[31:0], 32'b0};

  logic [63:0] r9_d, r9_num;
  logic [15:0] r9_temp;

  always_ff @(posedge clk) begin
    if (adv) begin
      r9_d    <= $signed(xp_w) >>> 33;
      r9_num  <= {20'b0, r8_nl} + {r8_nh[31:0], 32'b0};
      r9_temp <= r8_temp;
    end
  end

  // S10: magnitudes and sign for the divider
  logic [63:0] r10_ma, r10_mb;
  psc_side_t   r10_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      r10_ma          <= r9_num[63] ? (64'd0 - r9_num) : r9_num;
      r10_mb          <= r9_d[63] ? (64'd0 - r9_d) : r9_d;
      r10_side.temp   <= r9_temp;
      r10_side.neg    <= r9_num[63] ^ r9_d[63];
      r10_side.dvalid <= (r9_d != 64'd0);
    end
  end

  // --------------------------------------------------------------------------
  // divider
  // --------------------------------------------------------------------------
  logic [63:0] div_q;
  psc_side_t   div_side;

  psc_div u_div (
    .clk      (clk),
    .en       (adv),
    .num      (r10_ma),
    .den      (r10_mb),
    .side_in  (r10_side),
    .quo      (div_q),
    .side_out (div_side)
  );

  // --------------------------------------------------------------------------
  // back end: P7..P9 corrections
  // --------------------------------------------------------------------------
  // Q1: signed quotient
  logic [63:0] q1_p;
  psc_side_t   q1_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      q1_p    <= div_side.neg ? (64'd0 - div_q) : div_q;
      q1_side <= div_side;
    end
  end

  // Q2: s = p>>13, s*s limbs, p*P8 limbs
  logic [63:0] s_w, ssx_w;

  assign s_w   = $signed(q1_p) >>> 13;
  assign ssx_w = s_w[31:0] * s_w[63:32];

  logic        [63:0] q2_ssl, q2_p;
  logic        [31:0] q2_ssx;
  logic signed [48:0] q2_p8l, q2_p8h;
  psc_side_t          q2_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      q2_ssl  <= s_w[31:0] * s_w[31:0];
      q2_ssx  <= ssx_w[31:0];
      q2_p8l  <= $signed({1'b0, q1_p[31:0]}) * p8;
      q2_p8h  <= $signed({1'b0, q1_p[63:32]}) * p8;
      q2_p    <= q1_p;
      q2_side <= q1_side;
    end
  end

  // Q3: s^2 and the P8 term
  logic signed [63:0] e_p8l, e_p8h, prod8_w;

  assign e_p8l   = q2_p8l;
  assign e_p8h   = q2_p8h;
  assign prod8_w = e_p8l + (e_p8h << 32);

  logic [63:0] q3_ss, q3_v2, q3_p;
  psc_side_t   q3_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      q3_ss   <= q2_ssl + {q2_ssx[30:0], 1'b0, 32'b0};
      q3_v2   <= prod8_w >>> 19;
      q3_p    <= q2_p;
      q3_side <= q2_side;
    end
  end

  // Q4: s^2 times P9 limbs
  logic signed [48:0] q4_p9l, q4_p9h;
  logic        [63:0] q4_v2, q4_p;
  psc_side_t          q4_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      q4_p9l  <= $signed({1'b0, q3_ss[31:0]}) * p9;
      q4_p9h  <= $signed({1'b0, q3_ss[63:32]}) * p9;
      q4_v2   <= q3_v2;
      q4_p    <= q3_p;
      q4_side <= q3_side;
    end
  end

  // Q5: P9 product, p + v2
  logic signed [63:0] e_p9l, e_p9h;

  assign e_p9l = q4_p9l;
  assign e_p9h = q4_p9h;

  logic [63:0] q5_prod9, q5_sum;
  psc_side_t   q5_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      q5_prod9 <= e_p9l + (e_p9h << 32);
      q5_sum   <= q4_p + q4_v2;
      q5_side  <= q4_side;
    end
  end

  // Q6: add the P9 term (arithmetic shift kept apart from the unsigned sum)
  logic signed [63:0] v1_w;

  assign v1_w = $signed(q5_prod9) >>> 25;

  logic [63:0] q6_t;
  psc_side_t   q6_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      q6_t    <= q5_sum + v1_w;
      q6_side <= q5_side;
    end
  end

  // Q7: drop fraction guard, add P7 offset; output register
  logic signed [63:0] e_p7, res_w;

  assign e_p7  = p7;
  assign res_w = ($signed(q6_t) >>> 8) + (e_p7 <<< 4);

  logic [31:0] q7_press;
  logic [15:0] q7_temp;
  logic        q7_pvalid;

  always_ff @(posedge clk) begin
    if (adv) begin
      q7_press  <= q6_side.dvalid ? res_w[31:0] : 32'd0;
      q7_temp   <= q6_side.temp;
      q7_pvalid <= q6_side.dvalid;
    end
  end

  assign m_axis_tdata = {q7_press, q7_temp};
  assign m_axis_tuser = q7_pvalid;

endmodule

[rtl/core/psc_checker.sv]
// ----------------------------------------------------------------------------
// psc_checker: port-level checks for the compensation unit
// Reset, stall hold, flow control and zero-divisor output rules.
// ----------------------------------------------------------------------------
module psc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // pipe is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output word valid right after reset");

  // a stalled output word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output word changed");

  // with no word waiting at the output, the input side is open
  a_ready_open: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output empty");

  // zero divisor reports zero pressure
  a_zero_press: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[47:16] == 32'd0)
    else $error("pressure nonzero with flag clear");

endmodule

bind pressure_sensor_compensation_unit psc_checker u_psc_checker (.*);

[verif/pressure_sensor_compensation_checker.sv]
// ----------------------------------------------------------------------------
// pressure_sensor_compensation_checker: scoreboard for the compensation unit
// Tracks calibration writes, predicts temperature and pressure for every
// accepted reading pair and compares each output word in order.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation_checker import psc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [15:0] temp_centi;
    logic [31:0] press_q24_8;
    logic        press_ok;
  } reading_t;

  logic [47:0] temp_cal;
  logic [63:0] press_cal_a;
  logic [63:0] press_cal_b;
  logic [15:0] press_cal_9;
  reading_t    expected_readings[$];

  function automatic logic [63:0] asr(logic [63:0] v, int n);
    return $unsigned($signed(v) >>> n);
  endfunction

  function automatic logic [63:0] sx(logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

  // 64-bit wrapping datapath, arithmetic shifts, truncating division
  function automatic reading_t compensate(logic [19:0] raw_t, logic [19:0] raw_p);
    logic [63:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] v1, v2, diff, tf, a, b, d, p, num, ma, mb, q;
    logic signed [63:0] ts;
    reading_t r;
    adc_t = {44'd0, raw_t};
    adc_p = {44'd0, raw_p};
    t1 = {48'd0, temp_cal[15:0]};
    t2 = sx(temp_cal[31:16]);
    t3 = sx(temp_cal[47:32]);
    p1 = {48'd0, press_cal_a[15:0]};
    p2 = sx(press_cal_a[31:16]);
    p3 = sx(press_cal_a[47:32]);
    p4 = sx(press_cal_a[63:48]);
    p5 = sx(press_cal_b[15:0]);
    p6 = sx(press_cal_b[31:16]);
    p7 = sx(press_cal_b[47:32]);
    p8 = sx(press_cal_b[63:48]);
    p9 = sx(press_cal_9);
    v1 = asr(((adc_t >> 3) - (t1 << 1)) * t2, 11);
    diff = (adc_t >> 4) - t1;
    v2 = asr(asr(diff * diff, 12) * t3, 14);
    tf = v1 + v2;
    ts = $signed(asr(tf * 64'd5 + 64'd128, 8));
    if (ts > 32767) ts = 32767;
    if (ts < -32768) ts = -32768;
    r.temp_centi = ts[15:0];
    r.press_q24_8 = '0;
    r.press_ok = 1'b0;
    a = tf - 64'd128000;
    b = a * a * p6 + ((a * p5) << 17) + (p4 << 35);
    a = asr(a * a * p3, 8) + ((a * p2) << 12);
    d = asr(((64'd1 << 47) + a) * p1, 33);
    if (d != 0) begin
      p = 64'd1048576 - adc_p;
      num = ((p << 31) - b) * 64'd3125;
      ma = num[63] ? -num : num;
      mb = d[63] ? -d : d;
      q = ma / mb;
      p = (num[63] ^ d[63]) ? -q : q;
      v1 = asr(p9 * asr(p, 13) * asr(p, 13), 25);
      v2 = asr(p8 * p, 19);
      p = asr(p + v1 + v2, 8) + (p7 << 4);
      r.press_q24_8 = p[31:0];
      r.press_ok = 1'b1;
    end
    return r;
  endfunction

  assign pending = expected_readings.size();

  always @(posedge clk) begin
    reading_t want;
    int bad;
    bad = 0;
    if (rst) begin
      temp_cal <= '0;
      press_cal_a <= '0;
      press_cal_b <= '0;
      press_cal_9 <= '0;
      expected_readings.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegTempCoeffs:  temp_cal <= cfg_data[47:0];
          RegPressCoeffA: press_cal_a <= cfg_data;
          RegPressCoeffB: press_cal_b <= cfg_data;
          RegPressCoeffL: press_cal_9 <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_readings.push_back(compensate(s_axis_tdata[19:0], s_axis_tdata[39:20]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_readings.size() == 0) begin
          $error("output word with nothing expected");
          bad = bad + 1;
        end else begin
          want = expected_readings.pop_front();
          if (m_axis_tdata[15:0] !== want.temp_centi) begin
            $error("temperature_centi: expected %0d, got %0d",
                   $signed(want.temp_centi), $signed(m_axis_tdata[15:0]));
            bad = bad + 1;
          end
          if (m_axis_tdata[47:16] !== want.press_q24_8) begin
            $error("pressure_q24_8: expected %0h, got %0h",
                   want.press_q24_8, m_axis_tdata[47:16]);
            bad = bad + 1;
          end
          if (m_axis_tuser !== want.press_ok) begin
            $error("pressure_valid: expected %0b, got %0b", want.press_ok, m_axis_tuser);
            bad = bad + 1;
          end
        end
      end
      errors <= errors + bad;
    end
  end

endmodule

[verif/pressure_sensor_compensation_unit_tb.sv]
// ----------------------------------------------------------------------------
// pressure_sensor_compensation_unit_tb: stimulus and verdict
// Loads several calibration sets (zero, typical, extremes, random), streams
// directed and random reading pairs with random gaps and output stalls, and
// lets the checker score every output word.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation_unit_tb;
  import psc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // raw_temperature[19:0], raw_pressure[39:20]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // temperature_centi[15:0], pressure_q24_8[47:16]
  logic        m_axis_tuser;       // pressure_valid
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int          errors;
  int          pending;
  int          cycles = 0;
  bit          gaps_on = 1'b1;     // sender gaps enabled
  bit          stalls_on = 1'b1;   // receiver stalls enabled
  int          stall_left = 0;

  // 10-stage front end + 64-step divider + 7-stage back end
  localparam int Latency    = 81;
  localparam int CycleLimit = 600000;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pressure_sensor_compensation_unit DUT (.*);

  pressure_sensor_compensation_checker scoreboard (.*);

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stall after each taken word, stall-free when disabled
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (m_axis_tvalid && m_axis_tready && stalls_on) begin
      stall_left <= $urandom_range(0, 16);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_cal(input logic [2:0] idx, input logic [63:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one reading pair; valid stays up between back-to-back words
  task automatic send_reading(input logic [19:0] raw_t, input logic [19:0] raw_p);
    int gap;
    gap = gaps_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {raw_p, raw_t};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // drop valid and wait until every result has come back
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Latency + 20) @(posedge clk);
  endtask

  task automatic load_cal(input logic [47:0] tc, input logic [63:0] pa,
                          input logic [63:0] pb, input logic [15:0] p9);
    write_cal(RegTempCoeffs, {16'd0, tc});
    write_cal(RegPressCoeffA, pa);
    write_cal(RegPressCoeffB, pb);
    write_cal(RegPressCoeffL, {48'd0, p9});
  endtask

  task automatic directed_set;
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'h00000, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'h00000);
    send_reading(20'd519888, 20'd415148);
    send_reading(20'h80000, 20'h80000);
    send_reading(20'h7FFFF, 20'h7FFFF);
    send_reading(20'h55555, 20'hAAAAA);
  endtask

  // mostly plausible readings, some full range
  task automatic random_burst(input int count);
    logic [19:0] rt, rp;
    repeat (count) begin
      if ($urandom_range(0, 3) != 0) begin
        rt = 20'd440000 + 20'($urandom_range(0, 160000));
        rp = 20'd250000 + 20'($urandom_range(0, 300000));
      end else begin
        rt = 20'($urandom);
        rp = 20'($urandom);
      end
      send_reading(rt, rp);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // calibration never loaded: divisor zero, pressure flagged invalid
    directed_set();
    drain();

    // typical factory calibration
    load_cal({16'hFC18, 16'd26435, 16'd27504},
             {16'd2855, 16'd3024, 16'hD643, 16'd36477},
             {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
    directed_set();
    random_burst(60);
    // hold the sender until the pipeline is empty, then resume
    drain();
    stalls_on = 1'b0;
    gaps_on = 1'b0;
    random_burst(60);
    drain();
    stalls_on = 1'b1;
    gaps_on = 1'b1;

    // extremes: all ones, then most negative words, then most positive words
    load_cal('1, '1, '1, 16'hFFFF);
    directed_set();
    random_burst(30);
    drain();
    load_cal({3{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 16'h8000);
    random_burst(30);
    drain();
    load_cal({16'h7FFF, 16'h7FFF, 16'hFFFF}, {{3{16'h7FFF}}, 16'hFFFF},
             {4{16'h7FFF}}, 16'h7FFF);
    random_burst(30);
    drain();

    // unused indexes must be ignored
    write_cal(3'd4, '1);
    write_cal(3'd7, 64'h1234_5678_9ABC_DEF0);

    // random calibration sets
    repeat (6) begin
      load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
               16'($urandom));
      random_burst(35);
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/psc_pkg.sv
rtl/core/psc_div.sv
rtl/core/pressure_sensor_compensation_unit.sv
rtl/core/psc_checker.sv
verif/pressure_sensor_compensation_checker.sv
verif/pressure_sensor_compensation_unit_tb.sv
